>>> hw/rtl/chse_pkg.sv
// Package with the constants, types and helper functions of the Hermite segment evaluator.
`default_nettype none
package chse_pkg;

  localparam int TIME_W     = 32;
  localparam int DATA_W     = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DIV_STAGES = FRAC_BITS;
  localparam int H_W        = FRAC_BITS + 4;
  localparam int VD_W       = DATA_W + TIME_W;
  localparam int EXT_W      = DATA_W + TIME_W;
  localparam int ACC_W      = H_W + VD_W + 4;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [1:0] {
    PH_INTERP = 2'd0,
    PH_EXTRAP = 2'd1,
    PH_CLAMP  = 2'd2
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TIME = 3'd0,
    REG_END_TIME   = 3'd1,
    REG_START_POS  = 3'd2,
    REG_END_POS    = 3'd3,
    REG_START_VEL  = 3'd4,
    REG_END_VEL    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic                    vld;
    phase_e                  ph;
    logic signed [EXT_W-1:0] ext;
    logic [TIME_W-1:0]       rem;
    logic [FRAC_BITS-1:0]    q;
  } div_t;

  typedef struct packed {
    logic                    vld;
    phase_e                  ph;
    logic signed [EXT_W-1:0] ext;
  } meta_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } sat_t;

  // Clips a wide signed value to the data range and reports whether it was clipped.
  function automatic sat_t sat_data(input logic signed [ACC_W-1:0] x);
    sat_t r;
    if ((&x[ACC_W-1:DATA_W-1]) || !(|x[ACC_W-1:DATA_W-1])) begin
      r.sat = 1'b0;
      r.val = x[DATA_W-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = x[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cubic_hermite_segment_eval_top.sv
// Throughput: one transaction per cycle unless the output stalls.
// The 16-stage restoring divider is fully pipelined.
// The whole pipeline advances together whenever the output register is empty or taken.
// Reset clears all valid bits and sets every configuration register to zero.
// The product v*D of each velocity is kept in a register that follows the configuration.
`default_nettype none
module cubic_hermite_segment_eval_top import chse_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [TIME_W-1:0]    query_time_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [DATA_W-1:0]  position_o,
  output logic [1:0]                phase_o,
  output logic                      saturated_o
);

  logic [TIME_W-1:0]        start_time_q, end_time_q;
  logic signed [DATA_W-1:0] start_pos_q, end_pos_q, start_vel_q, end_vel_q;
  logic [TIME_W-1:0]        dur_w;
  logic signed [VD_W-1:0]   vd0_q, vd1_q;
  logic                     en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= '0;
      end_time_q   <= '0;
      start_pos_q  <= '0;
      end_pos_q    <= '0;
      start_vel_q  <= '0;
      end_vel_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_START_TIME: start_time_q <= cfg_data_i;
        REG_END_TIME:   end_time_q   <= cfg_data_i;
        REG_START_POS:  start_pos_q  <= cfg_data_i;
        REG_END_POS:    end_pos_q    <= cfg_data_i;
        REG_START_VEL:  start_vel_q  <= cfg_data_i;
        REG_END_VEL:    end_vel_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dur_w = end_time_q - start_time_q;

  always_ff @(posedge clk_i) begin
    vd0_q <= start_vel_q * $signed({1'b0, dur_w});
    vd1_q <= end_vel_q * $signed({1'b0, dur_w});
  end

  logic out_vld_q;
  assign en          = !out_vld_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_vld_q;

  // Input stage: classify the query and form the dividend.
  logic              s0_vld_q;
  phase_e            s0_ph_q;
  logic [TIME_W-1:0] s0_rem_q, s0_tx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en) begin
      s0_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (query_time_i < start_time_q) begin
        s0_ph_q <= PH_CLAMP;
      end else if (query_time_i >= end_time_q) begin
        s0_ph_q <= PH_EXTRAP;
      end else begin
        s0_ph_q <= PH_INTERP;
      end
      s0_rem_q <= query_time_i - start_time_q;
      s0_tx_q  <= query_time_i - end_time_q;
    end
  end

  // Restoring divider, one quotient bit per stage.
  div_t div_q [DIV_STAGES];
  div_t div_d [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    logic [TIME_W:0]         sh;
    logic [TIME_W-1:0]       rem_in;
    logic [FRAC_BITS-1:0]    q_in;
    logic                    vld_in;
    phase_e                  ph_in;
    logic signed [EXT_W-1:0] ext_in;
    if (g == 0) begin : g_first
      assign rem_in = s0_rem_q;
      assign q_in   = '0;
      assign vld_in = s0_vld_q;
      assign ph_in  = s0_ph_q;
      assign ext_in = end_vel_q * $signed({1'b0, s0_tx_q});
    end else begin : g_next
      assign rem_in = div_q[g-1].rem;
      assign q_in   = div_q[g-1].q;
      assign vld_in = div_q[g-1].vld;
      assign ph_in  = div_q[g-1].ph;
      assign ext_in = div_q[g-1].ext;
    end
    assign sh = {rem_in, 1'b0};
    always_comb begin
      div_d[g].vld = vld_in;
      div_d[g].ph  = ph_in;
      div_d[g].ext = ext_in;
      if (sh >= {1'b0, dur_w}) begin
        div_d[g].rem = TIME_W'(sh - {1'b0, dur_w});
        div_d[g].q   = {q_in[FRAC_BITS-2:0], 1'b1};
      end else begin
        div_d[g].rem = sh[TIME_W-1:0];
        div_d[g].q   = {q_in[FRAC_BITS-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_q[g] <= '0;
      end else if (en) begin
        div_q[g] <= div_d[g];
      end
    end
  end

  // Powers of s, basis functions, products and sum.
  meta_t m1_q, m2_q, h_q, p_q, a_q, b_q;
  logic [FRAC_BITS-1:0] m1_s_q, m1_s2_q, m2_s_q, m2_s2_q, m2_s3_q;
  logic [2*FRAC_BITS-1:0] sq_w, cu_w;
  logic signed [H_W-1:0] h00_q, h10_q, h01_q, h11_q;
  logic signed [H_W-1:0] hs_w, hs2_w, hs3_w;
  logic signed [H_W+DATA_W-1:0] pa_q, pb_q, pc_hi_q, pe_hi_q;
  logic signed [H_W+DATA_W:0]   pc_lo_q, pe_lo_q;
  logic signed [ACC_W-1:0] sum_ab_q, c_q, e_q, acc_q, sh_w, ext_w;
  sat_t sat_acc_w, sat_ext_w;

  localparam logic signed [H_W-1:0] H_ONE = H_W'(1) << FRAC_BITS;

  assign sq_w  = div_q[DIV_STAGES-1].q * div_q[DIV_STAGES-1].q;
  assign cu_w  = m1_s2_q * m1_s_q;
  assign hs_w  = $signed(H_W'(m2_s_q));
  assign hs2_w = $signed(H_W'(m2_s2_q));
  assign hs3_w = $signed(H_W'(m2_s3_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q      <= '0;
      m2_q      <= '0;
      h_q       <= '0;
      p_q       <= '0;
      a_q       <= '0;
      b_q       <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      m1_q      <= {div_q[DIV_STAGES-1].vld, div_q[DIV_STAGES-1].ph,
                    div_q[DIV_STAGES-1].ext};
      m2_q      <= m1_q;
      h_q       <= m2_q;
      p_q       <= h_q;
      a_q       <= p_q;
      b_q       <= a_q;
      out_vld_q <= b_q.vld;
    end
  end

  assign sh_w      = acc_q >>> FRAC_BITS;
  assign ext_w     = ACC_W'(b_q.ext) + ACC_W'(end_pos_q);
  assign sat_acc_w = sat_data(sh_w);
  assign sat_ext_w = sat_data(ext_w);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_s_q   <= div_q[DIV_STAGES-1].q;
      m1_s2_q  <= sq_w[2*FRAC_BITS-1:FRAC_BITS];

      m2_s_q   <= m1_s_q;
      m2_s2_q  <= m1_s2_q;
      m2_s3_q  <= cu_w[2*FRAC_BITS-1:FRAC_BITS];

      h00_q    <= (hs3_w <<< 1) - (hs2_w <<< 1) - hs2_w + H_ONE;
      h10_q    <= hs3_w - (hs2_w <<< 1) + hs_w;
      h01_q    <= (hs2_w <<< 1) + hs2_w - (hs3_w <<< 1);
      h11_q    <= hs3_w - hs2_w;

      pa_q     <= h00_q * start_pos_q;
      pb_q     <= h01_q * end_pos_q;
      pc_lo_q  <= h10_q * $signed({1'b0, vd0_q[DATA_W-1:0]});
      pc_hi_q  <= h10_q * $signed(vd0_q[VD_W-1:DATA_W]);
      pe_lo_q  <= h11_q * $signed({1'b0, vd1_q[DATA_W-1:0]});
      pe_hi_q  <= h11_q * $signed(vd1_q[VD_W-1:DATA_W]);

      sum_ab_q <= ACC_W'(pa_q) + ACC_W'(pb_q);
      c_q      <= (ACC_W'(pc_hi_q) <<< DATA_W) + ACC_W'(pc_lo_q);
      e_q      <= (ACC_W'(pe_hi_q) <<< DATA_W) + ACC_W'(pe_lo_q);

      acc_q    <= sum_ab_q + c_q + e_q;

      phase_o  <= b_q.ph;
      case (b_q.ph)
        PH_CLAMP: begin
          position_o  <= start_pos_q;
          saturated_o <= 1'b0;
        end
        PH_EXTRAP: begin
          position_o  <= sat_ext_w.val;
          saturated_o <= sat_ext_w.sat;
        end
        default: begin
          position_o  <= sat_acc_w.val;
          saturated_o <= sat_acc_w.sat;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the cubic Hermite segment evaluator with random handshake idling.
`default_nettype none
module testbench import chse_pkg::*;;

  typedef struct {
    logic signed [DATA_W-1:0] position;
    logic [1:0]               phase;
    logic                     saturated;
  } pos_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [DATA_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_W-1:0]    query_time = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [DATA_W-1:0] position;
  logic [1:0]           phase;
  logic                 saturated;

  logic [31:0] seg_t0, seg_t1, seg_p0, seg_p1, seg_v0, seg_v1;
  pos_result_t expected_pos[$];
  int  errors = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;
  int  hold_off = 0;

  cubic_hermite_segment_eval_top DUT (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .query_time_i(query_time), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .position_o(position), .phase_o(phase), .saturated_o(saturated)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [31:0] sat_clip(input logic signed [127:0] x, output logic sat);
    sat = 1'b0;
    if (x > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (x < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return x[31:0];
  endfunction

  function automatic pos_result_t hermite_eval(input logic [31:0] t);
    pos_result_t r;
    logic [63:0] d, rem, s, s2, s3;
    logic signed [127:0] acc, p0, p1, v0, v1, h00, h10, h01, h11;
    logic sat;
    p0 = $signed(seg_p0); p1 = $signed(seg_p1);
    v0 = $signed(seg_v0); v1 = $signed(seg_v1);
    r.saturated = 1'b0;
    if (t < seg_t0) begin
      r.position = seg_p0;
      r.phase = PH_CLAMP;
    end else if (t >= seg_t1) begin
      acc = p1 + v1 * $signed({96'd0, t - seg_t1});
      r.position = sat_clip(acc, sat);
      r.saturated = sat;
      r.phase = PH_EXTRAP;
    end else begin
      d = seg_t1 - seg_t0;
      rem = t - seg_t0;
      s = 0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem = rem << 1;
        s = s << 1;
        if (rem >= d) begin
          rem = rem - d;
          s[0] = 1'b1;
        end
      end
      s2 = (s * s) >> FRAC_BITS;
      s3 = (s2 * s) >> FRAC_BITS;
      h00 = 2 * $signed({64'd0, s3}) - 3 * $signed({64'd0, s2}) + (128'sd1 <<< FRAC_BITS);
      h10 = $signed({64'd0, s3}) - 2 * $signed({64'd0, s2}) + $signed({64'd0, s});
      h01 = 3 * $signed({64'd0, s2}) - 2 * $signed({64'd0, s3});
      h11 = $signed({64'd0, s3}) - $signed({64'd0, s2});
      acc = h00 * p0 + h01 * p1 + h10 * v0 * $signed({64'd0, d})
          + h11 * v1 * $signed({64'd0, d});
      acc = acc >>> FRAC_BITS;
      r.position = sat_clip(acc, sat);
      r.saturated = sat;
      r.phase = PH_INTERP;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pos_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pos.size() == 0) begin
        report_mismatch("unexpected transaction", position, 32'd0);
      end else begin
        e = expected_pos.pop_front();
        if (position !== e.position) report_mismatch("position", position, e.position);
        if (phase !== e.phase) report_mismatch("phase", 32'(phase), 32'(e.phase));
        if (saturated !== e.saturated) begin
          report_mismatch("saturated", 32'(saturated), 32'(e.saturated));
        end
      end
    end
  end

  // Receiver stall: random bursts, or a long hold-off when requested.
  always @(posedge clk) begin
    int n;
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 13);
      out_stall <= 1'b1;
      repeat (n - 1) @(posedge clk);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_START_TIME: seg_t0 = val;
      REG_END_TIME:   seg_t1 = val;
      REG_START_POS:  seg_p0 = val;
      REG_END_POS:    seg_p1 = val;
      REG_START_VEL:  seg_v0 = val;
      default:        seg_v1 = val;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_pos.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_segment(input logic [31:0] t0, t1, p0, p1, v0, v1);
    drain();
    write_reg(REG_START_TIME, t0);
    write_reg(REG_END_TIME, t1);
    write_reg(REG_START_POS, p0);
    write_reg(REG_END_POS, p1);
    write_reg(REG_START_VEL, v0);
    write_reg(REG_END_VEL, v1);
    cfg_we <= 1'b0;
  endtask

  task automatic send_query(input logic [31:0] t);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    query_time <= t;
    expected_pos.push_back(hermite_eval(t));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_time;
    case ($urandom_range(0, 5))
      0: return seg_t0 + $urandom_range(0, 3) - 1;
      1: return seg_t1 + $urandom_range(0, 3) - 1;
      2: return 32'h0;
      3: return 32'hFFFFFFFF;
      default: return (seg_t1 > seg_t0) ?
        seg_t0 + $urandom_range(0, seg_t1 - seg_t0) : $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_val;
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    endcase
  endfunction

  task automatic test_directed;
    set_segment(32'd100, 32'd1100, 32'h0001_0000, 32'h0005_0000, 32'h0000_0100,
                32'hFFFF_FF00);
    send_query(32'd0); send_query(32'd99); send_query(32'd100); send_query(32'd600);
    send_query(32'd1099); send_query(32'd1100); send_query(32'd5000);
    send_query(32'hFFFFFFFF);
    set_segment(32'd0, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000);
    send_query(32'd0); send_query(32'h7FFFFFFF); send_query(32'hFFFFFFFE);
    send_query(32'hFFFFFFFF);
    set_segment(32'd500, 32'd500, 32'h1234, 32'h5678, 32'h9, 32'h7FFFFFFF);
    send_query(32'd499); send_query(32'd500); send_query(32'hFFFFFFFF);
    set_segment(32'd900, 32'd10, 32'h80000000, 32'h80000000, 32'h0, 32'h80000000);
    send_query(32'd5); send_query(32'd10); send_query(32'd899); send_query(32'hFFFFFFFF);
  endtask

  task automatic test_random(input int phases, input int per_phase);
    logic [31:0] a, b;
    for (int p = 0; p < phases; p++) begin
      a = $urandom;
      b = $urandom_range(0, 3) == 0 ? $urandom : a + $urandom_range(1, 1 << $urandom_range(0, 31));
      set_segment(a, b, pick_val(), pick_val(), pick_val(), pick_val());
      for (int i = 0; i < per_phase; i++) send_query(pick_time());
    end
  endtask

  task automatic test_backpressure;
    hold_off = 200;
    for (int i = 0; i < 60; i++) send_query(pick_time());
    drain();
    for (int i = 0; i < 20; i++) send_query(pick_time());
  endtask

  initial begin
    ref_clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(20, 60);
    test_backpressure();
    idle_on = 1'b0;
    test_random(6, 60);
    drain();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  task automatic ref_clear;
    seg_t0 = 0; seg_t1 = 0; seg_p0 = 0; seg_p1 = 0; seg_v0 = 0; seg_v1 = 0;
  endtask
endmodule
`default_nettype wire

>>> sim.f
hw/rtl/chse_pkg.sv
hw/rtl/cubic_hermite_segment_eval_top.sv
bench/testbench.sv
